@@ rtl/b35sc_pkg.sv @@
// Package for the base-35 seed codec.
// Holds the radix constants, the digit alphabet, the controller state type and
// the command and status structs. No dependencies.
`timescale 1ns / 1ps

package b35sc_pkg;

  localparam int unsigned VAL_W      = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned MAX_DIGITS = 13;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned N_CHUNKS   = VAL_W / CHUNK_W;
  localparam int unsigned CI_W       = 2;
  localparam int unsigned PART_W     = DIGIT_W + CHUNK_W;
  localparam int unsigned RECIP_SH   = 27;
  localparam int unsigned RECIP_W    = 22;
  localparam logic [RECIP_W-1:0] RECIP = 22'd3834793;
  localparam logic [PART_W-1:0]  RADIX = 22'd35;
  localparam int unsigned DVAL_W     = 9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UO   = 8'h4F;
  localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EMIT_ENC,
    S_DEC_MUL,
    S_DEC_ADD,
    S_EMIT_DEC
  } state_t;

  typedef struct packed {
    logic load_enc;
    logic load_dec;
    logic div_step;
    logic dec_mul;
    logic dec_add;
    logic emit_enc;
    logic emit_dec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_end;
    logic enc_end;
    logic emit_end;
    logic dec_last;
    logic out_free;
  } ctrl_sts_t;

  // Digit value to its alphabet character: 0-9 then A-Z without O.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = 8'h00;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {2'b00, d};
    end else if (d < 6'd24) begin
      c = CHAR_UA + {2'b00, d} - 8'd10;
    end else if (d < 6'd35) begin
      c = CHAR_UA + {2'b00, d} - 8'd9;
    end
    return c;
  endfunction

endpackage

@@ rtl/b35sc_ctrl.sv @@
// Controller state machine of the base-35 seed codec.
// Sequences division steps, digit emission and decode accumulation.
// Depends on b35sc_pkg.
`timescale 1ns / 1ps

module b35sc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  req_type,
  input  b35sc_pkg::ctrl_sts_t  sts,
  output b35sc_pkg::ctrl_cmd_t  cmd
);
  import b35sc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = req_type ? S_DEC_MUL : S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_end && sts.enc_end) begin
          state_next = S_EMIT_ENC;
        end
      end
      S_EMIT_ENC: begin
        if (sts.out_free && sts.emit_end) begin
          state_next = S_IDLE;
        end
      end
      S_DEC_MUL: state_next = S_DEC_ADD;
      S_DEC_ADD: state_next = sts.dec_last ? S_EMIT_DEC : S_IDLE;
      S_EMIT_DEC: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        s_tready     = 1'b1;
        cmd.load_enc = s_tvalid && !req_type;
        cmd.load_dec = s_tvalid && req_type;
      end
      S_DIV:      cmd.div_step = 1'b1;
      S_EMIT_ENC: cmd.emit_enc = sts.out_free;
      S_DEC_MUL:  cmd.dec_mul  = 1'b1;
      S_DEC_ADD:  cmd.dec_add  = 1'b1;
      S_EMIT_DEC: cmd.emit_dec = sts.out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

@@ rtl/b35sc_dp.sv @@
// Datapath of the base-35 seed codec: chunked divide-by-35 unit, digit store,
// decode accumulator and output register.
// Depends on b35sc_pkg.
`timescale 1ns / 1ps

module b35sc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [b35sc_pkg::VAL_W-1:0]      seed_value,
  input  logic [b35sc_pkg::CHAR_W-1:0]     char_code,
  input  logic                             last_char,
  input  b35sc_pkg::ctrl_cmd_t             cmd,
  output b35sc_pkg::ctrl_sts_t             sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [b35sc_pkg::CHAR_W-1:0]     out_char,
  output logic                             out_last,
  output logic [b35sc_pkg::VAL_W-1:0]      decoded_value,
  output logic                             is_decode
);
  import b35sc_pkg::*;

  logic [VAL_W-1:0]   v;
  logic [DIGIT_W-1:0] r;
  logic [CI_W-1:0]    ci;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   e_idx;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

  logic [VAL_W-1:0]   acc;
  logic [VAL_W-1:0]   prod;
  logic [DVAL_W-1:0]  dval;
  logic               dec_last;

  logic [PART_W-1:0]            part;
  logic [PART_W+RECIP_W-1:0]    recip_prod;
  logic [CHUNK_W-1:0]           q_chunk;
  logic [PART_W-1:0]            rem_full;
  logic [DIGIT_W-1:0]           rem;
  logic [VAL_W-1:0]             v_step;

  logic [CHAR_W-1:0]  folded;
  logic [DVAL_W-1:0]  dval_new;

  // One 16-bit chunk of long division by 35 per cycle.
  assign part       = {r, v[VAL_W-1 -: CHUNK_W]};
  assign recip_prod = part * RECIP;
  assign q_chunk    = recip_prod[RECIP_SH +: CHUNK_W];
  assign rem_full   = part - ({{(PART_W-CHUNK_W){1'b0}}, q_chunk} * RADIX);
  assign rem        = rem_full[DIGIT_W-1:0];
  assign v_step     = {v[VAL_W-CHUNK_W-1:0], q_chunk};

  always_comb begin
    folded = char_code;
    if (char_code >= CHAR_LA && char_code <= CHAR_LZ) begin
      folded = char_code - CASE_GAP;
    end
    if (folded < CHAR_UA) begin
      dval_new = {1'b0, folded} - 9'd48;
    end else if (folded < CHAR_UO) begin
      dval_new = {1'b0, folded} - 9'd55;
    end else begin
      dval_new = {1'b0, folded} - 9'd56;
    end
  end

  assign sts.div_end  = (ci == CI_W'(N_CHUNKS - 1));
  assign sts.enc_end  = (v_step == '0) || (cnt == IDX_W'(MAX_DIGITS - 1));
  assign sts.emit_end = (e_idx == '0);
  assign sts.dec_last = dec_last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      ci    <= '0;
      e_idx <= '0;
      acc   <= '0;
    end else begin
      if (cmd.load_enc) begin
        cnt <= '0;
        ci  <= '0;
      end
      if (cmd.div_step) begin
        ci <= ci + 1'b1;
        if (sts.div_end) begin
          cnt   <= cnt + 1'b1;
          e_idx <= cnt;
        end
      end
      if (cmd.emit_enc) begin
        e_idx <= e_idx - 1'b1;
      end
      if (cmd.dec_add) begin
        acc <= prod + acc + {{(VAL_W-DVAL_W){dval[DVAL_W-1]}}, dval};
      end
      if (cmd.emit_dec) begin
        acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_enc) begin
      v <= seed_value;
      r <= '0;
    end
    if (cmd.div_step) begin
      v <= v_step;
      r <= sts.div_end ? '0 : rem;
      if (sts.div_end) begin
        digit_store[cnt] <= rem;
      end
    end
    if (cmd.load_dec) begin
      dval     <= dval_new;
      dec_last <= last_char;
    end
    if (cmd.dec_mul) begin
      prod <= {acc[VAL_W-6:0], 5'b0} + {acc[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_enc || cmd.emit_dec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_enc) begin
      out_char      <= digit_char(digit_store[e_idx]);
      out_last      <= (e_idx == '0);
      decoded_value <= '0;
      is_decode     <= 1'b0;
    end else if (cmd.emit_dec) begin
      out_char      <= '0;
      out_last      <= 1'b1;
      decoded_value <= acc;
      is_decode     <= 1'b1;
    end
  end

endmodule

@@ rtl/base35_seed_codec.sv @@
// Top level of the base-35 seed codec.
// Joins the controller and the datapath to the stream ports.
// Depends on b35sc_pkg, b35sc_ctrl and b35sc_dp.
`timescale 1ns / 1ps

// Converts between 64-bit values and base-35 text (0-9, A-Z without O).
// An encode beat (tuser 0) yields one to thirteen character beats, most
// significant first, the final one with tlast. Each digit is found by long
// division by 35 in four 16-bit chunks, one chunk per cycle, so an encode
// occupies the block while it takes the beat, divides out every digit and
// emits each character, and emission waits while the result side stalls.
// A decode beat (tuser 1) carries one character; the block takes the beat
// and passes it through the multiply-by-35 accumulator. The character with
// tlast also produces one result beat holding the value. One item is in work
// at a time, and a new one is taken while the last result beat still waits.

module base35_seed_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // seed_value [63:0], char_code [71:64]
  input  logic        s_tuser,   // req_type
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_char [7:0], decoded_value [71:8]
  output logic        m_tuser,   // is_decode
  output logic        m_tlast    // out_last
);
  import b35sc_pkg::*;

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic [CHAR_W-1:0]  out_char;
  logic [VAL_W-1:0]   decoded_value;

  b35sc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  b35sc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .seed_value    (s_tdata[VAL_W-1:0]),
    .char_code     (s_tdata[VAL_W +: CHAR_W]),
    .last_char     (s_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_char      (out_char),
    .out_last      (m_tlast),
    .decoded_value (decoded_value),
    .is_decode     (m_tuser)
  );

  assign m_tdata = {decoded_value, out_char};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid straight after reset");

  a_dec_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("decode result without last marker");

  a_enc_alphabet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (out_char != CHAR_UO) && (out_char >= CHAR_ZERO)
      && (decoded_value == '0))
    else $error("encode beat carries a character outside the alphabet");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("controller issued more than one command");

endmodule
